[rtl/core/sample_clock_pll_macros.svh]
// Assertion macros for the sample clock PLL; they compile to nothing for synthesis.
`ifndef SAMPLE_CLOCK_PLL_MACROS_SVH
`define SAMPLE_CLOCK_PLL_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every rising clock edge, ignored while reset is active.
`define SCPLL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked on every rising clock edge, also while reset is active.
`define SCPLL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define SCPLL_ASSERT(lbl, prop, msg)
`define SCPLL_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[rtl/core/scpll_pkg.sv]
// Shared widths, register indexes and types of the sample clock PLL.
`default_nettype none

package scpll_pkg;

  // Width of the time arithmetic; all time and period math wraps at this width.
  localparam int unsigned TIME_WIDTH  = 64;
  // Arrival and corrected times are one bit narrower than the arithmetic.
  localparam int unsigned STAMP_WIDTH = TIME_WIDTH - 1;
  localparam int unsigned SHIFT_WIDTH = 5;
  localparam int unsigned CFG_IDX_W   = 1;

  localparam logic [SHIFT_WIDTH-1:0] PHASE_SHIFT_RST = SHIFT_WIDTH'(7);
  localparam logic [SHIFT_WIDTH-1:0] FREQ_SHIFT_RST  = SHIFT_WIDTH'(10);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_SHIFT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_SHIFT  = CFG_IDX_W'(1);

  typedef logic [TIME_WIDTH-1:0]  time_t;
  typedef logic [STAMP_WIDTH-1:0] stamp_t;

  // Loop gain settings.
  typedef struct packed {
    logic [SHIFT_WIDTH-1:0] phase_shift;
    logic [SHIFT_WIDTH-1:0] freq_shift;
  } cfg_t;

  // One result beat as produced by the loop.
  typedef struct packed {
    stamp_t corrected_time;
    time_t  period;
    logic   locked;
    logic   period_positive;
  } result_t;

endpackage

`default_nettype wire

[rtl/core/sample_clock_pll.sv]
// Top level of the sample clock PLL: input register, loop update and result register.
//
//   channel  direction  handshake               payload
//   in       into       in_valid_i/in_stall_o   arrival_time_i
//   out      out of     out_valid_o/out_stall_i corrected_time_o, period_o, locked_o,
//                                               period_positive_o
//   cfg      into       cfg_we_i                cfg_index_i, cfg_wdata_i
//
// One beat per cycle is sustained while the output is not stalled; a result reaches the
// output register from the loop when its beat leaves the input register.
// The loop state update (adds, magnitude, shifts, compare) is one register-to-register step.
// Reset clears the loop state and loads the gains with their reset values; no clearing pass is needed.
// A stalled result holds in the output register while the input register takes one more
// beat; in_stall_o rises only when both registers are full and the output is stalled.
`default_nettype none

module sample_clock_pll
  import scpll_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output      logic                   in_stall_o,
  input  wire logic [STAMP_WIDTH-1:0] arrival_time_i,
  output      logic                   out_valid_o,
  input  wire logic                   out_stall_i,
  output      logic [STAMP_WIDTH-1:0] corrected_time_o,
  output      logic signed [TIME_WIDTH-1:0] period_o,
  output      logic                   locked_o,
  output      logic                   period_positive_o,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [SHIFT_WIDTH-1:0] cfg_wdata_i
);

`include "sample_clock_pll_macros.svh"

  cfg_t    cfg;
  result_t result;

  logic    in_valid_q, in_valid_d;
  stamp_t  arrival_q;
  logic    out_valid_q, out_valid_d;
  result_t out_q;
  logic    advance;
  logic    in_accept;

  scpll_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  scpll_loop u_loop (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .step_i    (advance),
    .arrival_i (arrival_q),
    .result_o  (result)
  );

  // The loop steps when the held beat can move into a free or draining result register.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_accept || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers load only on a moving beat.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      arrival_q <= arrival_time_i;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign corrected_time_o  = out_q.corrected_time;
  assign period_o          = out_q.period;
  assign locked_o          = out_q.locked;
  assign period_positive_o = out_q.period_positive;

  // The input side stalls only when the result register is full and stalled.
  `SCPLL_ASSERT(a_stall_cause, in_stall_o |-> (out_valid_q && out_stall_i), "stray input stall")
  // A held input beat is not dropped.
  `SCPLL_ASSERT(a_in_kept, (in_valid_q && !advance) |=> in_valid_q, "held input beat was lost")
  // A stalled result is not dropped.
  `SCPLL_ASSERT(a_out_kept, (out_valid_q && out_stall_i) |=> out_valid_q, "stalled result lost")
  // A stalled result keeps its payload.
  `SCPLL_ASSERT(a_out_held, (out_valid_q && out_stall_i) |=> $stable(out_q), "result changed")

endmodule

`default_nettype wire

[rtl/core/scpll_cfg_regs.sv]
// Configuration registers holding the phase and frequency loop shifts.
`default_nettype none

module scpll_cfg_regs
  import scpll_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [SHIFT_WIDTH-1:0] cfg_wdata_i,
  output cfg_t                        cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the register index of a write.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PHASE_SHIFT: cfg_d.phase_shift = cfg_wdata_i;
        CFG_FREQ_SHIFT:  cfg_d.freq_shift  = cfg_wdata_i;
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_shift <= PHASE_SHIFT_RST;
      cfg_q.freq_shift  <= FREQ_SHIFT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/core/scpll_loop.sv]
// Loop state and the combinational phase and period update for one arrival.
`default_nettype none

module scpll_loop
  import scpll_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire cfg_t   cfg_i,
  input  wire logic   step_i,
  input  wire stamp_t arrival_i,
  output result_t     result_o
);

  logic  time_seen_q, time_seen_d;
  time_t est_time_q, est_time_d;
  time_t est_period_q, est_period_d;

  time_t arrival;
  time_t period_seed;
  time_t advanced;
  time_t err;
  logic  err_neg;
  time_t err_mag;
  time_t phase_mag, freq_mag;
  time_t phase_corr, freq_corr;
  logic  locked;

  // Update path: reseed a zero period, advance, then correct by the scaled error.
  always_comb begin
    arrival     = {1'b0, arrival_i};
    period_seed = (est_period_q == '0) ? (arrival - est_time_q) : est_period_q;
    advanced    = est_time_q + period_seed;
    err         = arrival - advanced;
    err_neg     = err[TIME_WIDTH-1];
    err_mag     = err_neg ? (time_t'(0) - err) : err;
    // Scaling the magnitude and restoring the sign truncates toward zero.
    phase_mag   = err_mag >> cfg_i.phase_shift;
    freq_mag    = err_mag >> cfg_i.freq_shift;
    phase_corr  = err_neg ? (time_t'(0) - phase_mag) : phase_mag;
    freq_corr   = err_neg ? (time_t'(0) - freq_mag) : freq_mag;
    // Locked when the period is non-negative and at least twice the error magnitude.
    locked      = !period_seed[TIME_WIDTH-1] && (err_mag <= (period_seed >> 1));

    if (!time_seen_q) begin
      // The first arrival only seeds the time estimate.
      est_time_d   = arrival;
      est_period_d = est_period_q;
      locked       = 1'b0;
    end else begin
      est_time_d   = advanced + phase_corr;
      est_period_d = period_seed + freq_corr;
    end
    time_seen_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_seen_q  <= 1'b0;
      est_time_q   <= '0;
      est_period_q <= '0;
    end else if (step_i) begin
      time_seen_q  <= time_seen_d;
      est_time_q   <= est_time_d;
      est_period_q <= est_period_d;
    end
  end

  // Result of the step that is taken in this cycle.
  always_comb begin
    result_o.corrected_time  = est_time_d[STAMP_WIDTH-1:0];
    result_o.period          = est_period_d;
    result_o.locked          = locked;
    result_o.period_positive = !est_period_d[TIME_WIDTH-1] && (est_period_d != '0);
  end

endmodule

`default_nettype wire
